/* hdl/r2fft_pkg.sv */
package r2fft_pkg;

  localparam int MaxPoints  = 64;
  localparam int SampleBits = 16;
  localparam int DataW      = 24;
  localparam int TwW        = 17;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 3;

  localparam logic [CfgIdxW-1:0] RegInverse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSize    = 1'b1;

  localparam logic signed [DataW-1:0] AccMax = 24'sh7FFFFF;
  localparam logic signed [DataW-1:0] AccMin = -24'sh800000;

  // quarter-wave sine, signed q2.15 (17 bits), 64-point resolution
  function automatic logic signed [TwW-1:0] sine_quarter(input logic [4:0] r);
    logic signed [TwW-1:0] v;
    unique case (r)
      5'd0:  v = 17'sd0;
      5'd1:  v = 17'sd3212;
      5'd2:  v = 17'sd6393;
      5'd3:  v = 17'sd9512;
      5'd4:  v = 17'sd12540;
      5'd5:  v = 17'sd15447;
      5'd6:  v = 17'sd18205;
      5'd7:  v = 17'sd20788;
      5'd8:  v = 17'sd23170;
      5'd9:  v = 17'sd25330;
      5'd10: v = 17'sd27246;
      5'd11: v = 17'sd28899;
      5'd12: v = 17'sd30274;
      5'd13: v = 17'sd31357;
      5'd14: v = 17'sd32138;
      5'd15: v = 17'sd32610;
      5'd16: v = 17'sd32768;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TwW-1:0] sine64(input logic [5:0] a);
    logic [4:0] r;
    logic signed [TwW-1:0] v;
    r = {1'b0, a[3:0]};
    v = a[4] ? sine_quarter(5'd16 - r) : sine_quarter(r);
    return a[5] ? -v : v;
  endfunction

  function automatic logic signed [DataW-1:0] sat24(input logic signed [DataW+1:0] x);
    logic signed [DataW-1:0] y;
    if (x > $signed({{2{AccMax[DataW-1]}}, AccMax})) y = AccMax;
    else if (x < $signed({{2{AccMin[DataW-1]}}, AccMin})) y = AccMin;
    else y = x[DataW-1:0];
    return y;
  endfunction

  typedef struct packed {
    logic       load_we;
    logic [5:0] load_addr;
    logic       rd_en;
    logic [5:0] rd_p;
    logic [5:0] rd_q;
    logic [5:0] tw_angle;
    logic       mul_en;
    logic       bfly_wr;
    logic       scale_wr;
    logic       out_capture;
    logic [5:0] out_index;
    logic       out_last;
  } r2fft_cmd_t;

endpackage

/* hdl/r2fft_datapath.sv */
module r2fft_datapath #(
  parameter int MAX_POINTS  = r2fft_pkg::MaxPoints,
  parameter int SAMPLE_BITS = r2fft_pkg::SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  r2fft_pkg::r2fft_cmd_t         cmd_i,
  input  logic                          inverse_i,
  input  logic [2:0]                    log2_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [23:0]            bin_real_o,
  output logic signed [23:0]            bin_imag_o,
  output logic [5:0]                    bin_index_o,
  output logic                          last_bin_o
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = r2fft_pkg::DataW;

  logic signed [DW-1:0] mem_re [MAX_POINTS];
  logic signed [DW-1:0] mem_im [MAX_POINTS];

  logic signed [DW-1:0] ur_q, ui_q, br_q, bi_q;
  logic signed [DW-1:0] ur_d, ui_d;
  logic [5:0] p_q, q_q;
  logic signed [r2fft_pkg::TwW-1:0] wr, wi;
  logic signed [41:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
  logic signed [DW-1:0] su_r_q, su_i_q;
  logic signed [DW-1:0] in_r, in_i;
  logic signed [DW+1:0] tr, ti;
  logic signed [43:0] sr, si;
  logic signed [DW:0] rnd_r, rnd_i;
  logic signed [DW-1:0] sc_r, sc_i;
  logic [5:0] rnd_k;

  always_comb begin
    if (SAMPLE_BITS <= 16) begin
      in_r = DW'(sample_real_i) <<< (16 - SAMPLE_BITS);
      in_i = DW'(sample_imag_i) <<< (16 - SAMPLE_BITS);
    end else begin
      in_r = DW'(sample_real_i >>> (SAMPLE_BITS - 16));
      in_i = DW'(sample_imag_i >>> (SAMPLE_BITS - 16));
    end
  end

  always_comb begin
    wr = r2fft_pkg::sine64(cmd_i.tw_angle + 6'd16);
    wi = r2fft_pkg::sine64(cmd_i.tw_angle);
    if (inverse_i) wi = -wi;
  end

  // twiddle product, butterfly sums from registered products and inverse scaling
  always_comb begin
    sr = 44'(m_rr_q) - 44'(m_ii_q) + 44'sd16384;
    si = 44'(m_ri_q) + 44'(m_ir_q) + 44'sd16384;
    tr = (DW+2)'(sr >>> 15);
    ti = (DW+2)'(si >>> 15);
    rnd_k = 6'(1) << (log2_i - 3'd1);
    rnd_r = (DW+1)'(ur_q) + (DW+1)'(rnd_k);
    rnd_i = (DW+1)'(ui_q) + (DW+1)'(rnd_k);
    sc_r = DW'(rnd_r >>> log2_i);
    sc_i = DW'(rnd_i >>> log2_i);
    ur_d = r2fft_pkg::sat24((DW+2)'(su_r_q) + tr);
    ui_d = r2fft_pkg::sat24((DW+2)'(su_i_q) + ti);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem_re[cmd_i.load_addr[AW-1:0]] <= in_r;
      mem_im[cmd_i.load_addr[AW-1:0]] <= in_i;
    end else if (cmd_i.bfly_wr) begin
      mem_re[p_q[AW-1:0]] <= ur_d;
      mem_im[p_q[AW-1:0]] <= ui_d;
      mem_re[q_q[AW-1:0]] <= r2fft_pkg::sat24((DW+2)'(su_r_q) - tr);
      mem_im[q_q[AW-1:0]] <= r2fft_pkg::sat24((DW+2)'(su_i_q) - ti);
    end else if (cmd_i.scale_wr) begin
      mem_re[p_q[AW-1:0]] <= sc_r;
      mem_im[p_q[AW-1:0]] <= sc_i;
    end
    if (cmd_i.rd_en) begin
      ur_q <= mem_re[cmd_i.rd_p[AW-1:0]];
      ui_q <= mem_im[cmd_i.rd_p[AW-1:0]];
      br_q <= mem_re[cmd_i.rd_q[AW-1:0]];
      bi_q <= mem_im[cmd_i.rd_q[AW-1:0]];
      p_q  <= cmd_i.rd_p;
      q_q  <= cmd_i.rd_q;
    end
    if (cmd_i.mul_en) begin
      m_rr_q <= 42'(wr * br_q);
      m_ii_q <= 42'(wi * bi_q);
      m_ri_q <= 42'(wr * bi_q);
      m_ir_q <= 42'(wi * br_q);
      su_r_q <= ur_q;
      su_i_q <= ui_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_capture) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_capture) begin
      bin_real_o  <= ur_q;
      bin_imag_o  <= ui_q;
      bin_index_o <= cmd_i.out_index;
      last_bin_o  <= cmd_i.out_last;
    end
  end
endmodule

/* hdl/r2fft_ctrl.sv */
module r2fft_ctrl #(
  parameter int MAX_POINTS = r2fft_pkg::MaxPoints
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [r2fft_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [r2fft_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  output r2fft_pkg::r2fft_cmd_t cmd_o,
  output logic                  inverse_o,
  output logic [2:0]            log2_o
);
  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_MUL, S_WR, S_SRD, S_SWR, S_ORD, S_OUT
  } state_e;

  localparam int MaxL = $clog2(MAX_POINTS);

  state_e     state_q;
  logic       inv_q;
  logic [2:0] size_q;
  logic [6:0] cnt_q;
  logic [2:0] stg_q;
  logic [5:0] bfly_q;
  logic [2:0] l_eff;
  logic [6:0] n;
  logic [5:0] half, j, base, rev, p, q, ang;

  always_comb begin
    l_eff = (size_q == 3'd0) ? 3'd1 : size_q;
    if (int'(l_eff) > MaxL) l_eff = 3'(MaxL);
    n = 7'(1) << l_eff;
    half = 6'(1) << stg_q;
    j = bfly_q & (half - 6'd1);
    base = (bfly_q - j) << 1;
    p = base + j;
    q = p + half;
    ang = 6'(j << (3'd5 - stg_q));
    rev = '0;
    for (int k = 0; k < 6; k++) begin
      if (k < int'(l_eff)) rev[int'(l_eff) - 1 - k] = cnt_q[k];
    end
  end

  assign in_ready_o = (state_q == S_LOAD) && !cfg_we_i;
  assign inverse_o = inv_q;
  assign log2_o = l_eff;

  always_comb begin
    cmd_o = '0;
    cmd_o.load_we = in_valid_i && in_ready_o;
    cmd_o.load_addr = rev;
    cmd_o.tw_angle = ang;
    cmd_o.out_index = cnt_q[5:0];
    cmd_o.out_last = (cnt_q == n - 7'd1);
    unique case (state_q)
      S_RD:  begin cmd_o.rd_en = 1'b1; cmd_o.rd_p = p; cmd_o.rd_q = q; end
      S_MUL: cmd_o.mul_en = 1'b1;
      S_WR:  cmd_o.bfly_wr = 1'b1;
      S_SRD, S_ORD: begin cmd_o.rd_en = 1'b1; cmd_o.rd_p = cnt_q[5:0]; cmd_o.rd_q = cnt_q[5:0]; end
      S_SWR: cmd_o.scale_wr = 1'b1;
      S_OUT: cmd_o.out_capture = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      inv_q   <= 1'b0;
      size_q  <= 3'd6;
      cnt_q   <= '0;
      stg_q   <= '0;
      bfly_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        r2fft_pkg::RegInverse: inv_q  <= cfg_data_i[0];
        r2fft_pkg::RegSize:    size_q <= cfg_data_i;
        default: ;
      endcase
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: if (cmd_o.load_we) begin
          if (cnt_q == n - 7'd1) begin
            cnt_q <= '0; stg_q <= '0; bfly_q <= '0; state_q <= S_RD;
          end else cnt_q <= cnt_q + 7'd1;
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_WR;
        S_WR: begin
          if (7'(bfly_q) == (n >> 1) - 7'd1) begin
            bfly_q <= '0;
            if (stg_q == l_eff - 3'd1) begin
              cnt_q <= '0;
              state_q <= inv_q ? S_SRD : S_ORD;
            end else begin
              stg_q <= stg_q + 3'd1; state_q <= S_RD;
            end
          end else begin
            bfly_q <= bfly_q + 6'd1; state_q <= S_RD;
          end
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          if (cnt_q == n - 7'd1) begin cnt_q <= '0; state_q <= S_ORD; end
          else begin cnt_q <= cnt_q + 7'd1; state_q <= S_SRD; end
        end
        S_ORD: state_q <= S_OUT;
        S_OUT: if (cmd_o.out_capture) begin
          if (cnt_q == n - 7'd1) begin cnt_q <= '0; state_q <= S_LOAD; end
          else begin cnt_q <= cnt_q + 7'd1; state_q <= S_ORD; end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

/* hdl/radix2_fft_engine.sv */
// Iterative radix-2 decimation-in-time FFT, up to MAX_POINTS complex points.
// Samples load one per cycle while offered, into bit-reversed places of a work
// memory; after the last sample, one shared butterfly unit runs N/2*log2(N)
// butterflies, each in three steps (read, multiply, write back), inverse mode
// adds a scaling pass per point (read, write back), and bins leave in natural
// order, each read and then presented, held while the output is stalled. The
// single butterfly unit sets the pace, and a new frame loads only after the
// last bin is presented. A configuration write drops a partly loaded frame.
module radix2_fft_engine #(
  parameter int MAX_POINTS  = r2fft_pkg::MaxPoints,
  parameter int SAMPLE_BITS = r2fft_pkg::SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [r2fft_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [r2fft_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [23:0]            bin_real_o,
  output logic signed [23:0]            bin_imag_o,
  output logic [5:0]                    bin_index_o,
  output logic                          last_bin_o
);
  r2fft_pkg::r2fft_cmd_t cmd;
  logic       inverse;
  logic [2:0] log2n;

  r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .out_valid_i(out_valid_o), .out_ready_i,
    .cmd_o(cmd), .inverse_o(inverse), .log2_o(log2n)
  );

  r2fft_datapath #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .inverse_i(inverse), .log2_i(log2n),
    .sample_real_i, .sample_imag_i, .out_ready_i, .out_valid_o,
    .bin_real_o, .bin_imag_o, .bin_index_o, .last_bin_o
  );
endmodule

/* hdl/r2fft_checker.sv */
module r2fft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] bin_index_o,
  input logic       last_bin_o
);
  // output request holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_index_o))
    else $error("output request dropped while stalled");

  // no loading while bins are being sent
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_bin_o |-> !in_ready_o)
    else $error("input ready during emission");

  // after the last bin is taken the next bin starts at zero
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_bin_o ##1 out_valid_o && !$stable(bin_index_o)
      |-> bin_index_o == 6'd0)
    else $error("frame does not start at bin zero");
endmodule

bind radix2_fft_engine r2fft_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .bin_index_o, .last_bin_o
);

/* sim/tb_radix2_fft_engine.sv */
`timescale 1ns / 100ps

module tb_radix2_fft_engine;

  typedef enum logic {RowCfg, RowSample} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [r2fft_pkg::CfgIdxW-1:0]  idx;
    logic [r2fft_pkg::CfgDataW-1:0] data;
    int                             re;
    int                             im;
    bit                             typed;  // frame-closing row with bin 0 typed in
    int                             er;
    int                             ei;
  } stim_row_t;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [5:0]         idx;
    logic               last;
  } bin_t;

  localparam int SinTab[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                                25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
  localparam int RandItems = 256;
  localparam int IdleLimit = 20000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [r2fft_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [r2fft_pkg::CfgDataW-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [15:0]             sample_real_i;
  logic signed [15:0]             sample_imag_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [23:0]             bin_real_o;
  logic signed [23:0]             bin_imag_o;
  logic [5:0]                     bin_index_o;
  logic                           last_bin_o;

  radix2_fft_engine dut (.*);

  // predictor state
  bit          mdl_inverse;
  logic [2:0]  mdl_size;
  longint      mem_re[64];
  longint      mem_im[64];
  int          mdl_loaded;
  bin_t        bin_q[$];

  int  errors;
  int  bins_seen;
  bit  tx_calm;
  int  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip24(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic longint tw_sin(int a);
    int q;
    int r;
    longint v;
    q = (a >> 4) & 3;
    r = a & 15;
    v = (q & 1) ? SinTab[16 - r] : SinTab[r];
    return (q & 2) ? -v : v;
  endfunction

  function automatic int fft_log2();
    int l;
    l = mdl_size;
    if (l < 1) l = 1;
    if (l > 6) l = 6;
    return l;
  endfunction

  task automatic fft_butterflies(int l);
    int n;
    int half;
    int base;
    int j;
    int a;
    int p;
    int q;
    longint wr;
    longint wi;
    longint tr;
    longint ti;
    longint ur;
    longint ui;
    n = 1 << l;
    for (half = 1; half < n; half = half << 1) begin
      for (base = 0; base < n; base += 2 * half) begin
        for (j = 0; j < half; j++) begin
          a  = (j * (64 / (2 * half))) & 63;
          wr = tw_sin((a + 16) & 63);
          wi = mdl_inverse ? -tw_sin(a) : tw_sin(a);
          p  = base + j;
          q  = base + j + half;
          tr = (wr * mem_re[q] - wi * mem_im[q] + 16384) >>> 15;
          ti = (wr * mem_im[q] + wi * mem_re[q] + 16384) >>> 15;
          ur = mem_re[p];
          ui = mem_im[p];
          mem_re[p] = clip24(ur + tr);
          mem_im[p] = clip24(ui + ti);
          mem_re[q] = clip24(ur - tr);
          mem_im[q] = clip24(ui - ti);
        end
      end
    end
    if (mdl_inverse) begin
      for (j = 0; j < n; j++) begin
        mem_re[j] = clip24((mem_re[j] + (64'sd1 << (l - 1))) >>> l);
        mem_im[j] = clip24((mem_im[j] + (64'sd1 << (l - 1))) >>> l);
      end
    end
  endtask

  // load one sample; on the closing one, queue the whole spectrum
  task automatic fft_load(int re, int im);
    int l;
    int n;
    int pos;
    int k;
    bin_t b;
    l = fft_log2();
    n = 1 << l;
    if (mdl_loaded >= n) mdl_loaded = 0;
    pos = 0;
    for (k = 0; k < l; k++) pos |= ((mdl_loaded >> k) & 1) << (l - 1 - k);
    mem_re[pos] = re;
    mem_im[pos] = im;
    mdl_loaded++;
    if (mdl_loaded < n) return;
    mdl_loaded = 0;
    fft_butterflies(l);
    for (k = 0; k < n; k++) begin
      b.re   = mem_re[k][23:0];
      b.im   = mem_im[k][23:0];
      b.idx  = k[5:0];
      b.last = (k == n - 1);
      bin_q.push_back(b);
    end
  endtask

  task automatic write_reg(logic [r2fft_pkg::CfgIdxW-1:0] idx,
                           logic [r2fft_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == r2fft_pkg::RegInverse) mdl_inverse = data[0];
    else mdl_size = data;
    mdl_loaded = 0;
  endtask

  // lower the request, let all bins drain, then give the engine time to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bin_q.size() != 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic send_sample(int re, int im);
    if (!tx_calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    in_valid_i    <= 1'b1;
    sample_real_i <= re[15:0];
    sample_imag_i <= im[15:0];
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    fft_load(re, im);
  endtask

  function automatic int rand_sample();
    int pick;
    if ($urandom_range(99) < 15) begin
      pick = $urandom_range(3);
      case (pick)
        0: return 32767;
        1: return -32768;
        2: return 0;
        default: return -1;
      endcase
    end
    return $signed(16'($urandom));
  endfunction

  stim_row_t rows[] = '{
    '{RowCfg, r2fft_pkg::RegSize, 3'd1, 0, 0, 0, 0, 0},
    '{RowCfg, r2fft_pkg::RegInverse, 3'd0, 0, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 1000, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 1000, 0, 1, 2000, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 32767, 32767, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 32767, 32767, 1, 65534, 65534},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -32768, -32768, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -32768, -32768, 1, -65536, -65536},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 32767, -32768, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -32768, 32767, 0, 0, 0},
    '{RowCfg, r2fft_pkg::RegInverse, 3'd1, 0, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 32767, 32767, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 32767, 32767, 1, 32767, 32767},
    // size zero is raised to a two-point transform
    '{RowCfg, r2fft_pkg::RegSize, 3'd0, 0, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 12345, -1, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -1, 12345, 0, 0, 0},
    // partial frame dropped by a register write
    '{RowCfg, r2fft_pkg::RegSize, 3'd2, 0, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 111, -222, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -333, 444, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 555, 666, 0, 0, 0},
    '{RowCfg, r2fft_pkg::RegInverse, 3'd0, 0, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 16384, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 0, 16384, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, -16384, 0, 0, 0, 0},
    '{RowSample, r2fft_pkg::RegInverse, 3'd0, 0, -16384, 0, 0, 0}
  };

  initial begin
    int r;
    int sent;
    int phase;
    int frames;
    int n;
    int k;
    int tail;
    int pick;
    logic [2:0] sz;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sample_real_i = '0;
    sample_imag_i = '0;
    mdl_inverse   = 1'b0;
    mdl_size      = 3'd6;
    mdl_loaded    = 0;
    tx_calm       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < rows.size(); r++) begin
      if (rows[r].kind == RowCfg) begin
        drain();
        write_reg(rows[r].idx, rows[r].data);
      end else begin
        send_sample(rows[r].re, rows[r].im);
        if (rows[r].typed) begin
          k = bin_q.size() - (1 << fft_log2());
          bin_q[k].re = rows[r].er[23:0];
          bin_q[k].im = rows[r].ei[23:0];
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      drain();
      if (phase == 0) begin
        sz = 3'd6;
      end else if (phase == 1) begin
        sz = 3'd7;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) sz = 3'($urandom_range(3, 1));
        else if (pick < 85) sz = 3'($urandom_range(5, 4));
        else sz = (pick < 90) ? 3'd0 : (pick < 95 ? 3'd6 : 3'd7);
      end
      write_reg(r2fft_pkg::RegSize, sz);
      write_reg(r2fft_pkg::RegInverse, (phase == 1) ? 3'd1 : 3'($urandom_range(1)));
      n = 1 << fft_log2();
      frames = (n >= 32) ? 1 : $urandom_range(3, 1);
      // the first frame keeps offering samples while its bins are held off
      if (phase == 0) tail = 8;
      else tail = ($urandom_range(3) == 0) ? $urandom_range(n - 1, 1) : 0;
      for (k = 0; k < frames * n + tail && sent < RandItems; k++) begin
        tx_calm = (sent >= 100 && sent < 170);
        send_sample(rand_sample(), rand_sample());
        sent++;
      end
      phase++;
    end
    tx_calm = 1'b0;

    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    bit held;
    bin_t b;
    held        = 1'b0;
    errors      = 0;
    bins_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (bin_q.size() == 0) begin
          $display("%0t: unexpected bin, got re=%0d im=%0d idx=%0d last=%0b", $time,
                   bin_real_o, bin_imag_o, bin_index_o, last_bin_o);
          errors++;
        end else begin
          b = bin_q.pop_front();
          if (bin_real_o !== b.re) begin
            $display("%0t: bin_real exp %0d got %0d", $time, b.re, bin_real_o);
            errors++;
          end
          if (bin_imag_o !== b.im) begin
            $display("%0t: bin_imag exp %0d got %0d", $time, b.im, bin_imag_o);
            errors++;
          end
          if (bin_index_o !== b.idx) begin
            $display("%0t: bin_index exp %0d got %0d", $time, b.idx, bin_index_o);
            errors++;
          end
          if (last_bin_o !== b.last) begin
            $display("%0t: last_bin exp %0b got %0b", $time, b.last, last_bin_o);
            errors++;
          end
        end
        bins_seen++;
      end
      if (!held && bins_seen >= 40) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= (bins_seen >= 150 && bins_seen < 400) || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

/* files.f */
hdl/r2fft_pkg.sv
hdl/r2fft_datapath.sv
hdl/r2fft_ctrl.sv
hdl/radix2_fft_engine.sv
hdl/r2fft_checker.sv
sim/tb_radix2_fft_engine.sv
